// ===== sv/quadrature_detent_counter_macros.svh =====
// Assertion macros for the quadrature detent counter.
`ifndef QUADRATURE_DETENT_COUNTER_MACROS_SVH
`define QUADRATURE_DETENT_COUNTER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define QDC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("qdc assertion failed");
`define QDC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("qdc assertion failed");
`else
`define QDC_ASSERT_SAME(lbl, ante, cons)
`define QDC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== sv/qdc_pkg.sv =====
// Package: types, constants and helper functions of the quadrature detent counter.
package qdc_pkg;

    localparam int NUM_ENCODERS = 8;
    localparam int CH_W         = 3;
    localparam int CNT_W        = 16;
    localparam int RAW_W        = CNT_W + 1;
    localparam int DIV_W        = RAW_W + 1;
    localparam int DIV_ITER     = DIV_W / 2;
    localparam int ITER_W       = 4;
    localparam int CPD_W        = 4;

    localparam logic [CPD_W-1:0] CPD_RESET = 4'd4;
    localparam logic [1:0]       QUAD_JUMP = 2'b11;

    typedef enum logic [1:0] {
        OP_SAMPLE  = 2'd0,
        OP_CAPTURE = 2'd1,
        OP_READ    = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } t_dir;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_FIX,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic load;
        logic div_step;
        logic fix;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic is_read;
        logic div_last;
        logic out_free;
    } t_dp_sts;

    function automatic logic signed [1:0] quad_delta(input logic [3:0] code);
        logic signed [1:0] d;
        case (code)
            4'h1, 4'h7, 4'h8, 4'hE: d = -2'sd1;
            4'h2, 4'h4, 4'hB, 4'hD: d = 2'sd1;
            default:                d = 2'sd0;
        endcase
        return d;
    endfunction

    function automatic logic signed [CNT_W-1:0] sat16(input logic signed [21:0] v);
        logic signed [CNT_W-1:0] r;
        if (v > 22'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -22'sd32768) begin
            r = -16'sh8000;
        end else begin
            r = v[CNT_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== sv/qdc_if.sv =====
// Channel interfaces: input item and detent result.
interface qdc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [2:0] encoder_index;
    logic       level_a;
    logic       level_b;

    modport source (output valid, opcode, encoder_index, level_a, level_b, input ready);
    modport sink   (input valid, opcode, encoder_index, level_a, level_b, output ready);
endinterface

interface qdc_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] detent_step;
    logic [2:0]         read_index;

    modport source (output valid, detent_step, read_index, input ready);
    modport sink   (input valid, detent_step, read_index, output ready);
endinterface

// ===== sv/qdc_ctrl.sv =====
// Controller state machine sequencing sample, capture and read transactions.
module qdc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  qdc_pkg::t_dp_sts i_sts,
    output logic             o_in_ready,
    output qdc_pkg::t_dp_cmd o_cmd
);
    import qdc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_sts.is_read) n_state = ST_LOAD;
            end
            ST_LOAD: n_state = ST_DIV;
            ST_DIV: begin
                if (i_sts.div_last) n_state = ST_FIX;
            end
            ST_FIX:  n_state = ST_DONE;
            ST_DONE: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            ST_LOAD: o_cmd.load     = 1'b1;
            ST_DIV:  o_cmd.div_step = 1'b1;
            ST_FIX:  o_cmd.fix      = 1'b1;
            ST_DONE: o_cmd.finish   = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== sv/qdc_datapath.sv =====
// Datapath: per-channel state, transition decode, radix-4 divider and result register.
module qdc_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [qdc_pkg::CPD_W-1:0]       i_cfg_wdata,
    input  logic [1:0]                      i_opcode,
    input  logic [qdc_pkg::CH_W-1:0]        i_encoder_index,
    input  logic                            i_level_a,
    input  logic                            i_level_b,
    input  qdc_pkg::t_dp_cmd                i_cmd,
    input  logic                            i_out_ready,
    output qdc_pkg::t_dp_sts                o_sts,
    output logic                            o_out_valid,
    output logic signed [qdc_pkg::CNT_W-1:0] o_detent_step,
    output logic [qdc_pkg::CH_W-1:0]        o_read_index
);
    import qdc_pkg::*;

    logic [CPD_W-1:0]        r_cpd;
    logic signed [CNT_W-1:0] r_count [NUM_ENCODERS];
    logic signed [CNT_W-1:0] r_rem   [NUM_ENCODERS];
    logic [1:0]              r_lv    [NUM_ENCODERS];
    t_dir                    r_dir   [NUM_ENCODERS];

    logic [CH_W-1:0]         r_ch;
    logic signed [RAW_W-1:0] r_raw;
    logic [RAW_W-1:0]        r_mag;
    logic                    r_neg;
    logic [DIV_W-1:0]        r_q;
    logic [CPD_W-1:0]        r_dr;
    logic [ITER_W-1:0]       r_iter;
    logic signed [CNT_W-1:0] r_step;
    logic                    r_out_valid;
    logic signed [CNT_W-1:0] r_out_step;
    logic [CH_W-1:0]         r_out_ch;

    logic [CPD_W-1:0]        w_n;
    logic                    w_in_range;
    logic [1:0]              w_lv;
    logic [1:0]              w_prev;
    logic signed [2:0]       w_delta;
    logic signed [RAW_W-1:0] w_sum;
    logic signed [RAW_W-1:0] w_raw;
    logic [DIV_W-1:0]        n_q;
    logic [CPD_W-1:0]        n_dr;
    logic [CPD_W:0]          w_trial;
    logic [RAW_W-1:0]        w_smag;
    logic signed [DIV_W-1:0] w_sstep;
    logic signed [20:0]      w_prod;
    logic signed [21:0]      w_diff;
    logic                    w_out_free;

    assign w_n        = (r_cpd == '0) ? CPD_W'(1) : r_cpd;
    assign w_in_range = ({1'b0, i_encoder_index} < (CH_W + 1)'(NUM_ENCODERS));
    assign w_lv       = {i_level_a, i_level_b};
    assign w_prev     = r_lv[i_encoder_index];
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        w_delta = 3'(quad_delta({w_prev, w_lv}));
        if (w_delta == 3'sd0 && (w_prev ^ w_lv) == QUAD_JUMP) begin
            if (r_dir[i_encoder_index] == DIR_UP) begin
                w_delta = 3'sd2;
            end else if (r_dir[i_encoder_index] == DIR_DOWN) begin
                w_delta = -3'sd2;
            end
        end
    end

    assign w_sum = RAW_W'(r_count[i_encoder_index]) + RAW_W'(w_delta);
    assign w_raw = RAW_W'(r_count[r_ch]) + RAW_W'(r_rem[r_ch]);

    // two restoring steps per cycle
    always_comb begin
        n_q     = r_q;
        n_dr    = r_dr;
        w_trial = '0;
        for (int k = 0; k < 2; k++) begin
            w_trial = {n_dr, n_q[DIV_W-1]};
            n_q     = {n_q[DIV_W-2:0], 1'b0};
            if (w_trial >= {1'b0, w_n}) begin
                n_dr   = CPD_W'(w_trial - {1'b0, w_n});
                n_q[0] = 1'b1;
            end else begin
                n_dr = w_trial[CPD_W-1:0];
            end
        end
    end

    always_comb begin
        w_smag = r_q[RAW_W-1:0];
        if (r_q[RAW_W-1:0] == '0 && r_mag != '0 &&
            r_mag >= RAW_W'(w_n - CPD_W'(1))) begin
            w_smag = RAW_W'(1);
        end
        w_sstep = r_neg ? -$signed({1'b0, w_smag}) : $signed({1'b0, w_smag});
    end

    assign w_prod = r_step * $signed({1'b0, w_n});
    assign w_diff = 22'(r_raw) - 22'(w_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpd <= CPD_RESET;
        end else if (i_cfg_we) begin
            r_cpd <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_ENCODERS; i++) begin
                r_count[i] <= '0;
                r_rem[i]   <= '0;
                r_lv[i]    <= '0;
                r_dir[i]   <= DIR_NONE;
            end
        end else if (i_cmd.accept && w_in_range) begin
            case (i_opcode)
                OP_CAPTURE: begin
                    r_lv[i_encoder_index]    <= w_lv;
                    r_count[i_encoder_index] <= '0;
                    r_rem[i_encoder_index]   <= '0;
                    r_dir[i_encoder_index]   <= DIR_NONE;
                end
                OP_SAMPLE: begin
                    if (w_delta > 3'sd0) begin
                        r_dir[i_encoder_index] <= DIR_UP;
                    end else if (w_delta < 3'sd0) begin
                        r_dir[i_encoder_index] <= DIR_DOWN;
                    end
                    r_count[i_encoder_index] <= sat16(22'(w_sum));
                    r_lv[i_encoder_index]    <= w_lv;
                end
                default: ;
            endcase
        end else if (i_cmd.finish) begin
            r_count[r_ch] <= '0;
            r_rem[r_ch]   <= sat16(w_diff);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_ch <= i_encoder_index;
        end
        if (i_cmd.load) begin
            r_raw  <= w_raw;
            r_neg  <= w_raw[RAW_W-1];
            r_mag  <= w_raw[RAW_W-1] ? RAW_W'(-w_raw) : RAW_W'(w_raw);
            r_q    <= {1'b0, (w_raw[RAW_W-1] ? RAW_W'(-w_raw) : RAW_W'(w_raw))};
            r_dr   <= '0;
            r_iter <= '0;
        end
        if (i_cmd.div_step) begin
            r_q    <= n_q;
            r_dr   <= n_dr;
            r_iter <= r_iter + ITER_W'(1);
        end
        if (i_cmd.fix) begin
            r_step <= sat16(22'(w_sstep));
        end
        if (i_cmd.finish) begin
            r_out_step <= r_step;
            r_out_ch   <= r_ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.is_read  = (i_opcode == OP_READ) && w_in_range;
    assign o_sts.div_last = (r_iter == ITER_W'(DIV_ITER - 1));
    assign o_sts.out_free = w_out_free;
    assign o_out_valid    = r_out_valid;
    assign o_detent_step  = r_out_step;
    assign o_read_index   = r_out_ch;

endmodule

// ===== sv/quadrature_detent_counter.sv =====
// Top level of the multi-channel quadrature detent counter.
//
//  channel    dir  handshake      payload
//  i_in       in   valid/ready    opcode, encoder_index, level_a, level_b
//  o_out      out  valid/ready    detent_step, read_index
//  i_cfg_*    in   write enable   counts_per_detent (4 bits)
//
// Sample and capture are accepted in the idle state; a read then steps through
// the load, radix-4 divide, fix-up and write-back states before input is taken again.
// Reset is synchronous and needs no clearing pass; the channel state is in flops.
// A read whose result finds the output register still full waits in
// write-back until the result is taken; no input is taken meanwhile.
module quadrature_detent_counter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [qdc_pkg::CPD_W-1:0]   i_cfg_wdata,
    qdc_in_if.sink                      i_in,
    qdc_out_if.source                   o_out
);
    import qdc_pkg::*;
    `include "quadrature_detent_counter_macros.svh"

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    qdc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_sts      (w_sts),
        .o_in_ready (i_in.ready),
        .o_cmd      (w_cmd)
    );

    qdc_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_opcode        (i_in.opcode),
        .i_encoder_index (i_in.encoder_index),
        .i_level_a       (i_in.level_a),
        .i_level_b       (i_in.level_b),
        .i_cmd           (w_cmd),
        .i_out_ready     (o_out.ready),
        .o_sts           (w_sts),
        .o_out_valid     (o_out.valid),
        .o_detent_step   (o_out.detent_step),
        .o_read_index    (o_out.read_index)
    );

    `QDC_ASSERT_NEXT(a_read_blocks_input, i_in.valid && i_in.ready && w_sts.is_read, !i_in.ready)
    `QDC_ASSERT_SAME(a_finish_needs_room, w_cmd.finish, w_sts.out_free)
    `QDC_ASSERT_SAME(a_cmd_exclusive, 1'b1, $onehot0(w_cmd))
    `QDC_ASSERT_NEXT(a_finish_shows_result, w_cmd.finish, o_out.valid)

endmodule
